// ===== rtl/iamc_pkg.sv =====
// package for the idle / active mode controller
// types, register map, reset values and codes shared by the cfg, state and top rtl files
// no dependencies
package iamc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    localparam logic [23:0] IDLE_TIMEOUT_RST  = 24'd30000;
    localparam logic [15:0] IDLE_BLINK_RST    = 16'd500;
    localparam logic [15:0] HEARTBEAT_RST     = 16'd500;
    localparam logic [15:0] BEACON_PERIOD_RST = 16'd5000;
    localparam logic [15:0] COMM_PERIOD_RST   = 16'd100;

    typedef enum logic [2:0] {
        REG_IDLE_TIMEOUT  = 3'd0,
        REG_IDLE_BLINK    = 3'd1,
        REG_HEARTBEAT     = 3'd2,
        REG_BEACON_PERIOD = 3'd3,
        REG_COMM_PERIOD   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ACQ  = 2'd1,
        MODE_COMM = 2'd2,
        MODE_REC  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_STOP   = 2'd1,
        CMD_RESUME = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [23:0] idle_timeout;
        logic [15:0] idle_blink_period;
        logic [15:0] active_heartbeat_period;
        logic [15:0] beacon_period;
        logic [15:0] comm_period;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        ble_connected;
        logic        tcp_client;
        logic        ble_rec_tx;
        logic        wake_pending;
        logic        stop_pending;
        logic        trigger_fired;
        logic [31:0] send_return_ms;
    } t_tick;

    typedef struct packed {
        t_mode mode;
        logic  report_valid;
        t_mode reported_mode;
        t_cmd  sensor_command;
        logic  acquire_triggers;
        logic  send_beacon;
        logic  send_telemetry;
        logic  acquire_before_send;
        logic  green_led;
        logic  red_led;
        logic  wake_taken;
        logic  stop_taken;
    } t_res;

endpackage

// ===== rtl/iamc_if.sv =====
// valid / ready channel interfaces for tick beats and result beats
// no dependencies
interface iamc_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        ble_connected;
    logic        tcp_client;
    logic        ble_rec_tx;
    logic        wake_pending;
    logic        stop_pending;
    logic        trigger_fired;
    logic [31:0] send_return_ms;

    modport source (
        output valid, now_ms, ble_connected, tcp_client, ble_rec_tx,
               wake_pending, stop_pending, trigger_fired, send_return_ms,
        input  ready
    );
    modport sink (
        input  valid, now_ms, ble_connected, tcp_client, ble_rec_tx,
               wake_pending, stop_pending, trigger_fired, send_return_ms,
        output ready
    );
endinterface

interface iamc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       report_valid;
    logic [1:0] reported_mode;
    logic [1:0] sensor_command;
    logic       acquire_triggers;
    logic       send_beacon;
    logic       send_telemetry;
    logic       acquire_before_send;
    logic       green_led;
    logic       red_led;
    logic       wake_taken;
    logic       stop_taken;

    modport source (
        output valid, mode, report_valid, reported_mode, sensor_command,
               acquire_triggers, send_beacon, send_telemetry,
               acquire_before_send, green_led, red_led, wake_taken, stop_taken,
        input  ready
    );
    modport sink (
        input  valid, mode, report_valid, reported_mode, sensor_command,
               acquire_triggers, send_beacon, send_telemetry,
               acquire_before_send, green_led, red_led, wake_taken, stop_taken,
        output ready
    );
endinterface

// ===== rtl/iamc_cfg.sv =====
// apb configuration registers: timeout and the four periods
// depends on iamc_pkg
module iamc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iamc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [iamc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iamc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output iamc_pkg::t_cfg                     o_cfg
);

    iamc_pkg::t_cfg   r_cfg;
    iamc_pkg::t_reg_idx idx;
    logic             wr_en;

    assign idx    = iamc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout            <= iamc_pkg::IDLE_TIMEOUT_RST;
            r_cfg.idle_blink_period       <= iamc_pkg::IDLE_BLINK_RST;
            r_cfg.active_heartbeat_period <= iamc_pkg::HEARTBEAT_RST;
            r_cfg.beacon_period           <= iamc_pkg::BEACON_PERIOD_RST;
            r_cfg.comm_period             <= iamc_pkg::COMM_PERIOD_RST;
        end else if (wr_en) begin
            case (idx)
                iamc_pkg::REG_IDLE_TIMEOUT:  r_cfg.idle_timeout <= pwdata[23:0];
                iamc_pkg::REG_IDLE_BLINK:    r_cfg.idle_blink_period <= pwdata[15:0];
                iamc_pkg::REG_HEARTBEAT:     r_cfg.active_heartbeat_period <= pwdata[15:0];
                iamc_pkg::REG_BEACON_PERIOD: r_cfg.beacon_period <= pwdata[15:0];
                iamc_pkg::REG_COMM_PERIOD:   r_cfg.comm_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            iamc_pkg::REG_IDLE_TIMEOUT:  prdata = {8'd0, r_cfg.idle_timeout};
            iamc_pkg::REG_IDLE_BLINK:    prdata = {16'd0, r_cfg.idle_blink_period};
            iamc_pkg::REG_HEARTBEAT:     prdata = {16'd0, r_cfg.active_heartbeat_period};
            iamc_pkg::REG_BEACON_PERIOD: prdata = {16'd0, r_cfg.beacon_period};
            iamc_pkg::REG_COMM_PERIOD:   prdata = {16'd0, r_cfg.comm_period};
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/iamc_state.sv =====
// mode state, deadlines and led levels with the per-tick update logic
// depends on iamc_pkg
module iamc_state #(
    parameter int TIME_BITS = iamc_pkg::TIME_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iamc_pkg::t_cfg  i_cfg,
    input  iamc_pkg::t_tick i_tick,
    input  logic            i_step,
    output iamc_pkg::t_res  o_res
);

    localparam int MSB = TIME_BITS - 1;

    iamc_pkg::t_mode r_mode, n_mode, r_last, n_last, mode1;
    logic [MSB:0]    r_act, n_act, r_beacon, n_beacon, r_led, n_led, r_comm, n_comm;
    logic            r_snap, n_snap, r_green, n_green, r_red, n_red;

    logic [MSB:0] now, ret, el, c2, lag;
    logic [MSB:0] blink, hb, beacon_p, comm_p;
    logic         link, timed;

    function automatic logic reached(input logic [MSB:0] t, input logic [MSB:0] dl);
        logic [MSB:0] d;
        d = t - dl;
        return !d[MSB];
    endfunction

    assign now      = i_tick.now_ms[MSB:0];
    assign ret      = i_tick.send_return_ms[MSB:0];
    assign link     = i_tick.ble_connected || i_tick.tcp_client || i_tick.ble_rec_tx;
    assign blink    = TIME_BITS'(i_cfg.idle_blink_period);
    assign hb       = TIME_BITS'(i_cfg.active_heartbeat_period);
    assign beacon_p = TIME_BITS'(i_cfg.beacon_period);
    assign comm_p   = TIME_BITS'(i_cfg.comm_period);

    always_comb begin
        n_mode   = r_mode;
        n_last   = r_last;
        n_act    = i_tick.trigger_fired ? now : r_act;
        n_beacon = r_beacon;
        n_led    = r_led;
        n_comm   = r_comm;
        n_snap   = r_snap;
        n_green  = r_green;
        n_red    = r_red;
        el       = now - n_act;
        timed    = !el[MSB] && (32'(el) >= 32'(i_cfg.idle_timeout));
        c2       = '0;
        lag      = '0;
        o_res    = '0;

        // transition phase
        if (r_mode == iamc_pkg::MODE_IDLE) begin
            o_res.wake_taken = i_tick.wake_pending;
            if (i_tick.wake_pending || link) begin
                n_mode = iamc_pkg::MODE_COMM;
                o_res.sensor_command = iamc_pkg::CMD_RESUME;
                n_red  = 1'b0;
                n_led  = now;
                n_comm = now;
                n_snap = 1'b0;
            end else if (reached(now, r_led)) begin
                n_led   = now + blink;
                n_green = 1'b0;
                n_red   = !r_red;
            end
        end else begin
            o_res.stop_taken = i_tick.stop_pending;
            if ((timed && !link) || i_tick.stop_pending) begin
                n_mode   = iamc_pkg::MODE_IDLE;
                o_res.sensor_command = iamc_pkg::CMD_STOP;
                n_green  = 1'b0;
                n_red    = 1'b0;
                n_led    = now;
                n_beacon = now;
            end else if (i_tick.ble_rec_tx) begin
                n_mode = iamc_pkg::MODE_REC;
                n_led  = now + hb;
            end else begin
                if (r_mode == iamc_pkg::MODE_REC) begin
                    n_mode = iamc_pkg::MODE_COMM;
                    n_led  = now;
                end
                if (reached(now, n_led)) begin
                    n_led   = now + hb;
                    n_red   = 1'b0;
                    n_green = !r_green;
                end
            end
        end

        // report phase
        mode1 = n_mode;
        o_res.reported_mode = mode1;
        o_res.report_valid  = (mode1 != r_last);
        n_last = mode1;

        // send phase
        if (mode1 == iamc_pkg::MODE_IDLE) begin
            o_res.acquire_triggers = 1'b1;
            if (reached(now, n_beacon)) begin
                n_beacon = now + beacon_p;
                o_res.send_beacon = 1'b1;
            end
            n_snap = 1'b0;
        end else if (reached(now, n_comm)) begin
            o_res.send_telemetry      = 1'b1;
            o_res.acquire_before_send = !n_snap;
            c2  = n_comm + comm_p;
            lag = ret - c2;
            if (!lag[MSB] && (lag > comm_p)) begin
                n_comm = ret + comm_p;
            end else begin
                n_comm = c2;
            end
            n_snap = 1'b1;
            if (mode1 != iamc_pkg::MODE_REC) begin
                n_mode = iamc_pkg::MODE_ACQ;
            end
        end

        o_res.mode      = n_mode;
        o_res.green_led = n_green;
        o_res.red_led   = n_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= iamc_pkg::MODE_COMM;
            r_last   <= iamc_pkg::MODE_COMM;
            r_act    <= '0;
            r_beacon <= '0;
            r_led    <= '0;
            r_comm   <= '0;
            r_snap   <= 1'b0;
            r_green  <= 1'b0;
            r_red    <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_last   <= n_last;
            r_act    <= n_act;
            r_beacon <= n_beacon;
            r_led    <= n_led;
            r_comm   <= n_comm;
            r_snap   <= n_snap;
            r_green  <= n_green;
            r_red    <= n_red;
        end
    end

endmodule

// ===== rtl/idle_active_mode_controller.sv =====
// a tick beat is held in the input register, then its result beat in the result register
// throughput: one tick beat per cycle while the result register is empty or taken; the state
//   update is combinational between the input register and the result register
// reset: synchronous active low; mode comm, all deadlines and the activity time at zero,
//   leds off, registers at their documented defaults, both registers empty
module idle_active_mode_controller #(
    parameter int TIME_BITS = iamc_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [iamc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [iamc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [iamc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    iamc_tick_if.sink                       i_tick,
    iamc_res_if.source                      o_res
);

    iamc_pkg::t_cfg  cfg;
    iamc_pkg::t_tick r_in, in_beat;
    iamc_pkg::t_res  r_res, step_res;
    logic            r_in_valid, n_in_valid, r_out_valid, n_out_valid;
    logic            advance, accept;

    iamc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    iamc_state #(
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_tick  (r_in),
        .i_step  (advance),
        .o_res   (step_res)
    );

    assign in_beat.now_ms         = i_tick.now_ms;
    assign in_beat.ble_connected  = i_tick.ble_connected;
    assign in_beat.tcp_client     = i_tick.tcp_client;
    assign in_beat.ble_rec_tx     = i_tick.ble_rec_tx;
    assign in_beat.wake_pending   = i_tick.wake_pending;
    assign in_beat.stop_pending   = i_tick.stop_pending;
    assign in_beat.trigger_fired  = i_tick.trigger_fired;
    assign in_beat.send_return_ms = i_tick.send_return_ms;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || advance;
    assign accept       = i_tick.valid && i_tick.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= in_beat;
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.mode                = r_res.mode;
    assign o_res.report_valid        = r_res.report_valid;
    assign o_res.reported_mode       = r_res.reported_mode;
    assign o_res.sensor_command      = r_res.sensor_command;
    assign o_res.acquire_triggers    = r_res.acquire_triggers;
    assign o_res.send_beacon         = r_res.send_beacon;
    assign o_res.send_telemetry      = r_res.send_telemetry;
    assign o_res.acquire_before_send = r_res.acquire_before_send;
    assign o_res.green_led           = r_res.green_led;
    assign o_res.red_led             = r_res.red_led;
    assign o_res.wake_taken          = r_res.wake_taken;
    assign o_res.stop_taken          = r_res.stop_taken;

    a_acq_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.acquire_before_send |-> r_res.send_telemetry)
        else $error("acquire before send without a send");

    a_send_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.send_telemetry |->
            (r_res.mode == iamc_pkg::MODE_ACQ) || (r_res.mode == iamc_pkg::MODE_REC))
        else $error("telemetry send outside an active mode");

    a_beacon_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.send_beacon |->
            (r_res.mode == iamc_pkg::MODE_IDLE) && r_res.acquire_triggers)
        else $error("beacon outside idle");

    a_one_flag_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.wake_taken && r_res.stop_taken))
        else $error("wake and stop consumed on the same tick");

    a_stop_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.sensor_command == iamc_pkg::CMD_STOP) |->
            r_res.report_valid && (r_res.reported_mode == iamc_pkg::MODE_IDLE))
        else $error("sensor stop without an idle report");

endmodule
